@@ rtl/bclpd_pkg.sv @@
// ----------------------------------------------------------------------------
// bclpd_pkg: shared types and constants of the button chord decoder
// Event codes, register indexes, register reset values and the per-button
// status that travels from the debouncers to the event logic.
// ----------------------------------------------------------------------------
`default_nettype none

package bclpd_pkg;

   // width of the hold and debounce registers
   localparam int CFG_W = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [1:0] CSR_LONG_HOLD  = 2'd1;
   localparam logic [1:0] CSR_CHORD_HOLD = 2'd2;

   // register values after reset
   localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_HOLD_RST  = 16'd800;
   localparam logic [CFG_W-1:0] CHORD_HOLD_RST = 16'd1500;

   // button positions in the raw level vector
   localparam int BTN_LEFT  = 0;
   localparam int BTN_OK    = 1;
   localparam int BTN_RIGHT = 2;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_OK         = 3'd1,
      EV_LEFT       = 3'd2,
      EV_RIGHT      = 3'd3,
      EV_LEFT_LONG  = 3'd4,
      EV_RIGHT_LONG = 3'd5,
      EV_BACK       = 3'd6,
      EV_MODE       = 3'd7
   } event_type;

   // debounced view of one button for the current poll
   typedef struct packed {
      logic stable;     // debounced level after this poll, 0 = held
      logic pressed;    // stable level fell in this poll
      logic released;   // stable level rose in this poll
   } btn_status_type;

endpackage

`default_nettype wire

@@ rtl/bclpd_debounce.sv @@
// ----------------------------------------------------------------------------
// bclpd_debounce: debouncer for one active-low button
// Tracks the last raw level and when it changed; the stable level follows
// the raw level once it has been unchanged for longer than the debounce time.
// ----------------------------------------------------------------------------
`default_nettype none

module bclpd_debounce #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          raw,
   input  wire logic [TIME_BITS-1:0]          now,
   input  wire logic [bclpd_pkg::CFG_W-1:0]   debounce_ms,
   output bclpd_pkg::btn_status_type          status
);
   import bclpd_pkg::*;

   logic                 raw_prev_ff, raw_prev_in;
   logic                 stable_ff, stable_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;
   logic [TIME_BITS-1:0] quiet_time;
   logic                 settle;

   // a raw edge restarts the quiet time, so it cannot settle in the same poll
   assign quiet_time     = now - change_time_ff;
   assign settle         = (raw == raw_prev_ff) &&
                           (quiet_time > TIME_BITS'(debounce_ms)) &&
                           (raw != stable_ff);
   assign raw_prev_in    = raw;
   assign change_time_in = (raw != raw_prev_ff) ? now : change_time_ff;
   assign stable_in      = settle ? raw : stable_ff;

   assign status.stable   = stable_in;
   assign status.pressed  = settle && !raw;
   assign status.released = settle && raw;

   // state update once per poll
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff    <= 1'b1;
         stable_ff      <= 1'b1;
         change_time_ff <= '0;
      end else if (enable) begin
         raw_prev_ff    <= raw_prev_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bclpd_decide.sv @@
// ----------------------------------------------------------------------------
// bclpd_decide: event logic over the debounced buttons
// Keeps the pending flags, press times and chord tracking, and picks one
// event code per poll by fixed priority.
// ----------------------------------------------------------------------------
`default_nettype none

module bclpd_decide #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              enable,
   input  wire logic [TIME_BITS-1:0]              now,
   input  wire logic                              allow_long,
   input  wire logic                              raw_left,
   input  wire logic                              raw_right,
   input  bclpd_pkg::btn_status_type [2:0]        btn,
   input  wire logic [bclpd_pkg::CFG_W-1:0]       long_hold_ms,
   input  wire logic [bclpd_pkg::CFG_W-1:0]       chord_hold_ms,
   output bclpd_pkg::event_type                   event_code
);
   import bclpd_pkg::*;

   logic                 left_wait_ff, left_wait_in;
   logic                 right_wait_ff, right_wait_in;
   logic                 chord_on_ff, chord_on_in;
   logic                 chord_fired_ff, chord_fired_in;
   logic [TIME_BITS-1:0] chord_start_ff, chord_start_in;
   logic [TIME_BITS-1:0] left_press_ff, left_press_in;
   logic [TIME_BITS-1:0] right_press_ff, right_press_in;
   logic [TIME_BITS-1:0] chord_age, left_age, right_age;
   logic                 left_down, right_down;
   logic                 left_pend, right_pend;
   event_type            ev;

   assign left_down  = !btn[BTN_LEFT].stable;
   assign right_down = !btn[BTN_RIGHT].stable;

   // a fresh press restarts its side's hold time
   assign left_press_in  = btn[BTN_LEFT].pressed  ? now : left_press_ff;
   assign right_press_in = btn[BTN_RIGHT].pressed ? now : right_press_ff;
   assign left_pend      = btn[BTN_LEFT].pressed  || left_wait_ff;
   assign right_pend     = btn[BTN_RIGHT].pressed || right_wait_ff;

   // hold ages; a chord that starts now has age zero
   assign chord_age = now - (chord_on_ff ? chord_start_ff : now);
   assign left_age  = now - left_press_in;
   assign right_age = now - right_press_in;

   // priority: chord, chord release, ok, long presses, short releases
   always_comb begin
      left_wait_in   = left_pend;
      right_wait_in  = right_pend;
      chord_on_in    = chord_on_ff;
      chord_fired_in = chord_fired_ff;
      chord_start_in = chord_start_ff;
      ev             = EV_NONE;
      if (left_down && right_down) begin
         if (!chord_on_ff) begin
            chord_on_in    = 1'b1;
            chord_fired_in = 1'b0;
            chord_start_in = now;
         end
         if (!chord_fired_in && (chord_age >= TIME_BITS'(chord_hold_ms))) begin
            chord_fired_in = 1'b1;
            left_wait_in   = 1'b0;
            right_wait_in  = 1'b0;
            ev             = EV_MODE;
         end
      end else if (chord_on_ff) begin
         if (!left_down && !right_down) begin
            ev             = chord_fired_ff ? EV_NONE : EV_BACK;
            chord_on_in    = 1'b0;
            chord_fired_in = 1'b0;
            left_wait_in   = 1'b0;
            right_wait_in  = 1'b0;
         end
      end else if (btn[BTN_OK].pressed) begin
         ev = EV_OK;
      end else if (allow_long && left_down && left_pend && !raw_left && raw_right &&
                   (left_age >= TIME_BITS'(long_hold_ms))) begin
         left_wait_in = 1'b0;
         ev           = EV_LEFT_LONG;
      end else if (allow_long && right_down && right_pend && !raw_right && raw_left &&
                   (right_age >= TIME_BITS'(long_hold_ms))) begin
         right_wait_in = 1'b0;
         ev            = EV_RIGHT_LONG;
      end else if (btn[BTN_LEFT].released && left_pend) begin
         left_wait_in = 1'b0;
         ev           = EV_LEFT;
      end else if (btn[BTN_RIGHT].released && right_pend) begin
         right_wait_in = 1'b0;
         ev            = EV_RIGHT;
      end
   end

   assign event_code = ev;

   // state update once per poll
   always_ff @(posedge clock) begin
      if (reset) begin
         left_wait_ff   <= 1'b0;
         right_wait_ff  <= 1'b0;
         chord_on_ff    <= 1'b0;
         chord_fired_ff <= 1'b0;
         chord_start_ff <= '0;
         left_press_ff  <= '0;
         right_press_ff <= '0;
      end else if (enable) begin
         left_wait_ff   <= left_wait_in;
         right_wait_ff  <= right_wait_in;
         chord_on_ff    <= chord_on_in;
         chord_fired_ff <= chord_fired_in;
         chord_start_ff <= chord_start_in;
         left_press_ff  <= left_press_in;
         right_press_ff <= right_press_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/button_chord_long_press_decoder.sv @@
// Pipeline: a poll passes the input register, then the result register.
// Throughput: one poll per clock cycle while the event channel is not stalled;
//   the debouncers and event logic update all their state between the two registers.
// Reset: synchronous; clears both pipeline valids, all buttons to released,
//   all flags and times to zero, and loads the register defaults.
// ----------------------------------------------------------------------------
// button_chord_long_press_decoder: three-button event decoder
// Debounces left, ok and right, tracks the left plus right chord and long
// presses, and gives one event code for every poll.
// ----------------------------------------------------------------------------
`default_nettype none

module button_chord_long_press_decoder #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // poll channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [2:0]                        req_raw_buttons,
   input  wire logic [31:0]                       req_now_ms,
   input  wire logic                              req_allow_long,
   // event channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [2:0]                             rsp_event_code,
   // register write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [bclpd_pkg::CFG_W-1:0]       csr_wdata
);
   import bclpd_pkg::*;

   logic                  in_v_ff, in_v_in;
   logic [2:0]            raw_ff;
   logic [31:0]           now_ff;
   logic                  allow_ff;
   logic                  out_v_ff, out_v_in;
   event_type             event_ff;
   logic [CFG_W-1:0]      debounce_ff, long_hold_ff, chord_hold_ff;
   logic                  load, advance, csr_write;
   logic [TIME_BITS-1:0]  now_t;
   btn_status_type [2:0]  btn;
   event_type             event_next;

   // handshakes
   assign advance   = in_v_ff && (!out_v_ff || !rsp_stall);
   assign req_stall = in_v_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign in_v_in   = load || (in_v_ff && !advance);
   assign out_v_in  = advance || (out_v_ff && rsp_stall);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RST;
         long_hold_ff  <= LONG_HOLD_RST;
         chord_hold_ff <= CHORD_HOLD_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            CSR_LONG_HOLD:  long_hold_ff  <= csr_wdata;
            CSR_CHORD_HOLD: chord_hold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         raw_ff   <= req_raw_buttons;
         now_ff   <= req_now_ms;
         allow_ff <= req_allow_long;
      end
   end

   assign now_t = TIME_BITS'(now_ff);

   // one debouncer per button
   for (genvar i = 0; i < 3; i++) begin : g_btn
      bclpd_debounce #(
         .TIME_BITS (TIME_BITS)
      ) u_debounce (
         .clock       (clock),
         .reset       (reset),
         .enable      (advance),
         .raw         (raw_ff[i]),
         .now         (now_t),
         .debounce_ms (debounce_ff),
         .status      (btn[i])
      );
   end

   bclpd_decide #(
      .TIME_BITS (TIME_BITS)
   ) u_decide (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .now           (now_t),
      .allow_long    (allow_ff),
      .raw_left      (raw_ff[BTN_LEFT]),
      .raw_right     (raw_ff[BTN_RIGHT]),
      .btn           (btn),
      .long_hold_ms  (long_hold_ff),
      .chord_hold_ms (chord_hold_ff),
      .event_code    (event_next)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff <= event_next;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_event_code = event_ff;

   // checks
   a_fill_empty_result: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !out_v_ff |=> out_v_ff)
      else $error("held poll did not move into an empty result register");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_v_ff && out_v_ff && rsp_stall)
      else $error("poll channel stalled without a blocked result");

   a_debounce_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_index == CSR_DEBOUNCE) |=> debounce_ff == $past(csr_wdata))
      else $error("debounce register write lost");

   a_chord_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_index == CSR_CHORD_HOLD) |=> chord_hold_ff == $past(csr_wdata))
      else $error("chord hold register write lost");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the button chord long press decoder
// Polls are queued as short button gestures on a running millisecond clock,
// driven with random gaps and stalls, and every event code is compared with
// a local copy of the debouncers, chord and long-press logic.
// ----------------------------------------------------------------------------
module tb;
   import bclpd_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 3;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 10;

   // index past the register list, writes to it are dropped
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // raw level patterns, active low: bit0 left, bit1 ok, bit2 right
   localparam logic [2:0] RAW_IDLE  = 3'b111;
   localparam logic [2:0] RAW_OK    = 3'b101;
   localparam logic [2:0] RAW_LEFT  = 3'b110;
   localparam logic [2:0] RAW_RIGHT = 3'b011;
   localparam logic [2:0] RAW_CHORD = 3'b010;

   typedef struct packed {
      logic [2:0]  raw;
      logic [31:0] now_ms;
      logic        allow;
   } poll_type;

   typedef enum int {
      G_OK_TAP, G_LEFT_TAP, G_RIGHT_TAP, G_LEFT_LONG, G_RIGHT_LONG,
      G_CHORD_MODE, G_CHORD_BACK, G_STAGGER, G_BOUNCE, G_ANY, G_JUMP
   } gesture_kind;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_raw_buttons = RAW_IDLE;
   logic [31:0]          req_now_ms = '0;
   logic                 req_allow_long = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_event_code;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = CSR_DEBOUNCE;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // stimulus and scoreboard
   poll_type             poll_queue[$];
   event_type            expected_events[$];
   logic [31:0]          clock_ms;
   int unsigned          polls_queued = 0;
   int unsigned          events_checked = 0;
   int unsigned          error_count = 0;
   int unsigned          quiet_cycles = 0;
   int unsigned          src_gap = 0;
   int unsigned          stall_left = 0;
   int unsigned          hold_off_asks = 0;
   int unsigned          hold_off_seen = 0;
   logic                 src_idling = 1'b1;
   logic                 sink_idling = 1'b1;

   // local copy of the decoder state and registers
   logic [2:0]           raw_last;
   logic [2:0]           level;
   logic [31:0]          raw_edge_ms[3];
   logic [31:0]          left_down_ms;
   logic [31:0]          right_down_ms;
   logic                 left_pending;
   logic                 right_pending;
   logic                 chord_active;
   logic                 chord_done;
   logic [31:0]          chord_begin_ms;
   logic [CFG_W-1:0]     debounce_cfg;
   logic [CFG_W-1:0]     long_hold_cfg;
   logic [CFG_W-1:0]     chord_hold_cfg;

   always #HALF_PERIOD clock = ~clock;

   button_chord_long_press_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_buttons (req_raw_buttons),
      .req_now_ms      (req_now_ms),
      .req_allow_long  (req_allow_long),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // state of the decoder straight after reset
   function automatic void restore_power_on();
      int b;
      raw_last = RAW_IDLE;
      level = RAW_IDLE;
      for (b = 0; b < 3; b++) raw_edge_ms[b] = '0;
      left_down_ms = '0;
      right_down_ms = '0;
      left_pending = 1'b0;
      right_pending = 1'b0;
      chord_active = 1'b0;
      chord_done = 1'b0;
      chord_begin_ms = '0;
      debounce_cfg = DEBOUNCE_RST;
      long_hold_cfg = LONG_HOLD_RST;
      chord_hold_cfg = CHORD_HOLD_RST;
   endfunction

   // debounce one poll and work out the event it raises
   function automatic event_type decode_poll(logic [2:0] raw, logic [31:0] now, logic allow);
      logic [2:0]  fell;
      logic [2:0]  rose;
      logic [31:0] quiet;
      logic        left_held;
      logic        right_held;
      logic        short_chord;
      int          b;
      fell = '0;
      rose = '0;
      for (b = 0; b < 3; b++) begin
         if (raw[b] != raw_last[b]) begin
            raw_edge_ms[b] = now;
            raw_last[b] = raw[b];
         end
         quiet = now - raw_edge_ms[b];
         if (quiet > debounce_cfg && raw[b] != level[b]) begin
            level[b] = raw[b];
            if (raw[b]) rose[b] = 1'b1;
            else fell[b] = 1'b1;
         end
      end
      left_held = !level[BTN_LEFT];
      right_held = !level[BTN_RIGHT];

      // a fresh side press arms its click and long timers
      if (fell[BTN_LEFT]) begin
         left_pending = 1'b1;
         left_down_ms = now;
      end
      if (fell[BTN_RIGHT]) begin
         right_pending = 1'b1;
         right_down_ms = now;
      end

      // chord of both sides wins over everything else
      if (left_held && right_held) begin
         if (!chord_active) begin
            chord_active = 1'b1;
            chord_done = 1'b0;
            chord_begin_ms = now;
         end
         quiet = now - chord_begin_ms;
         if (!chord_done && quiet >= chord_hold_cfg) begin
            chord_done = 1'b1;
            left_pending = 1'b0;
            right_pending = 1'b0;
            return EV_MODE;
         end
         return EV_NONE;
      end

      // chord ends only once both sides are up
      if (chord_active) begin
         if (!left_held && !right_held) begin
            short_chord = !chord_done;
            chord_active = 1'b0;
            chord_done = 1'b0;
            left_pending = 1'b0;
            right_pending = 1'b0;
            return short_chord ? EV_BACK : EV_NONE;
         end
         return EV_NONE;
      end

      if (fell[BTN_OK]) return EV_OK;

      // long holds, held off while the other side reads pressed
      quiet = now - left_down_ms;
      if (allow && left_held && left_pending && !raw_last[BTN_LEFT] && raw_last[BTN_RIGHT] &&
          quiet >= long_hold_cfg) begin
         left_pending = 1'b0;
         return EV_LEFT_LONG;
      end
      quiet = now - right_down_ms;
      if (allow && right_held && right_pending && !raw_last[BTN_RIGHT] && raw_last[BTN_LEFT] &&
          quiet >= long_hold_cfg) begin
         right_pending = 1'b0;
         return EV_RIGHT_LONG;
      end

      // short clicks on release
      if (rose[BTN_LEFT] && left_pending) begin
         left_pending = 1'b0;
         return EV_LEFT;
      end
      if (rose[BTN_RIGHT] && right_pending) begin
         right_pending = 1'b0;
         return EV_RIGHT;
      end
      return EV_NONE;
   endfunction

   // gap length: mostly short, now and then long
   function automatic int unsigned pick_gap_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 93) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void report_error(string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%s", what);
   endfunction

   task automatic queue_poll(logic [2:0] raw, logic allow);
      poll_queue.push_back('{raw: raw, now_ms: clock_ms, allow: allow});
      polls_queued++;
   endtask

   task automatic poll_after(logic [2:0] raw, logic allow, logic [31:0] step);
      clock_ms += step;
      queue_poll(raw, allow);
   endtask

   // keep one raw pattern for a span of milliseconds, polled at random instants
   task automatic hold_raw(logic [2:0] raw, logic allow, logic [31:0] span);
      logic [31:0] spent;
      logic [31:0] remain;
      logic [31:0] step;
      int unsigned pick;
      spent = '0;
      queue_poll(raw, allow);
      while (spent < span) begin
         remain = span - spent;
         pick = $urandom_range(0, 99);
         if (pick < 30) step = remain;
         else if (pick < 35) step = '0;
         else if (pick < 45) step = 32'd1;
         else step = $urandom_range(1, remain);
         clock_ms += step;
         spent += step;
         queue_poll(raw, allow ^ ($urandom_range(0, 9) == 0));
      end
   endtask

   // random gestures, mostly well formed, some bounce and noise
   task automatic queue_random(int unsigned count);
      int unsigned goal;
      gesture_kind kind;
      logic        allow;
      logic [31:0] settle;
      logic [31:0] extra;
      goal = polls_queued + count;
      while (polls_queued < goal) begin
         allow = ($urandom_range(0, 9) < 7);
         settle = debounce_cfg + 32'd1;
         extra = $urandom_range(0, debounce_cfg / 2 + 3);
         if ($urandom_range(0, 99) < 75) kind = gesture_kind'($urandom_range(0, G_STAGGER));
         else kind = gesture_kind'($urandom_range(G_BOUNCE, G_JUMP));
         case (kind)
            G_OK_TAP:     hold_raw(RAW_OK, allow, settle + extra);
            G_LEFT_TAP:   hold_raw(RAW_LEFT, allow, settle + extra);
            G_RIGHT_TAP:  hold_raw(RAW_RIGHT, allow, settle + extra);
            G_LEFT_LONG:  hold_raw(RAW_LEFT, allow, settle + long_hold_cfg + extra);
            G_RIGHT_LONG: hold_raw(RAW_RIGHT, allow, settle + long_hold_cfg + extra);
            G_CHORD_MODE: hold_raw(RAW_CHORD, allow, settle + chord_hold_cfg + extra);
            G_CHORD_BACK: hold_raw(RAW_CHORD, allow, settle + $urandom_range(0, chord_hold_cfg));
            G_STAGGER: begin
               // one side first, then both, then one side let go
               hold_raw($urandom_range(0, 1) ? RAW_LEFT : RAW_RIGHT, allow,
                        $urandom_range(0, settle + long_hold_cfg));
               hold_raw(RAW_CHORD, allow, $urandom_range(0, settle + chord_hold_cfg + extra));
               hold_raw($urandom_range(0, 1) ? RAW_LEFT : RAW_RIGHT, allow,
                        $urandom_range(0, settle * 2));
            end
            G_BOUNCE: begin
               repeat ($urandom_range(2, 5))
                  hold_raw(3'($urandom_range(0, 7)), allow, $urandom_range(0, settle));
            end
            G_ANY: hold_raw(3'($urandom_range(0, 7)), allow,
                            $urandom_range(0, settle + long_hold_cfg));
            default: begin
               // far jump of the timestamp, differences wrap
               clock_ms += $urandom();
               hold_raw(3'($urandom_range(0, 7)), allow, $urandom_range(0, settle));
            end
         endcase
         hold_raw(RAW_IDLE, allow, settle + extra);
      end
   endtask

   // register write, only issued with the decoder idle
   task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEBOUNCE:   debounce_cfg = value;
         CSR_LONG_HOLD:  long_hold_cfg = value;
         CSR_CHORD_HOLD: chord_hold_cfg = value;
         default: ;
      endcase
   endtask

   // sender pauses until every event is back, then the pipeline settles
   task automatic wait_drained();
      while (poll_queue.size() != 0 || req_valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // poll driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (src_gap != 0) begin
            req_valid <= 1'b0;
            src_gap <= src_gap - 1;
         end else if (poll_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_raw_buttons <= poll_queue[0].raw;
            req_now_ms <= poll_queue[0].now_ms;
            req_allow_long <= poll_queue[0].allow;
            void'(poll_queue.pop_front());
            if (src_idling && $urandom_range(0, 99) >= 60) src_gap <= pick_gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // event stall: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (hold_off_seen != hold_off_asks) begin
         hold_off_seen <= hold_off_asks;
         stall_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (sink_idling && $urandom_range(0, 99) < 25) stall_left <= pick_gap_len();
      end
   end

   // every accepted poll beat yields one expected event
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_events.push_back(decode_poll(req_raw_buttons, req_now_ms, req_allow_long));
   end

   // compare each event beat with the oldest expectation
   always @(posedge clock) begin : event_check
      event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            report_error($sformatf("event %0d: none expected, got %0d",
                                   events_checked, rsp_event_code));
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_code !== want)
               report_error($sformatf("event %0d: expected %s (%0d), got %0d",
                                      events_checked, want.name(), want, rsp_event_code));
         end
         events_checked++;
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      restore_power_on();
      clock_ms = 32'hFFFF_FFFF;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed walk through ok, left, right long, mode and back events with reset registers, across the wrap
      queue_poll(RAW_IDLE, 1'b1);
      poll_after(RAW_IDLE, 1'b1, 1);
      poll_after(RAW_OK, 1'b0, 10);
      poll_after(RAW_OK, 1'b0, 50);          // exactly the debounce time, not yet
      poll_after(RAW_OK, 1'b0, 1);           // ok
      poll_after(RAW_LEFT, 1'b1, 10);        // ok up, left down together
      poll_after(RAW_LEFT, 1'b1, 51);
      poll_after(RAW_IDLE, 1'b1, 100);
      poll_after(RAW_IDLE, 1'b1, 51);        // left click
      poll_after(RAW_RIGHT, 1'b1, 10);
      poll_after(RAW_RIGHT, 1'b1, 51);
      poll_after(RAW_RIGHT, 1'b1, 799);      // one short of the long hold
      poll_after(RAW_RIGHT, 1'b1, 1);        // right long
      poll_after(RAW_LEFT, 1'b0, 10);        // right up with nothing pending
      poll_after(RAW_LEFT, 1'b0, 51);
      poll_after(RAW_LEFT, 1'b0, 900);       // long hold disabled
      poll_after(RAW_IDLE, 1'b0, 10);
      poll_after(RAW_IDLE, 1'b0, 51);        // falls back to a left click
      poll_after(RAW_CHORD, 1'b1, 10);
      poll_after(RAW_CHORD, 1'b1, 51);
      poll_after(RAW_CHORD, 1'b1, 1500);     // mode switch
      poll_after(RAW_IDLE, 1'b1, 10);
      poll_after(RAW_IDLE, 1'b1, 51);        // fired chord ends quietly
      poll_after(RAW_CHORD, 1'b1, 10);
      poll_after(RAW_CHORD, 1'b1, 51);
      poll_after(RAW_IDLE, 1'b1, 10);
      poll_after(RAW_IDLE, 1'b1, 51);        // short chord gives back
      wait_drained();

      // all registers at zero, no idling on either side
      src_idling = 1'b0;
      sink_idling = 1'b0;
      write_reg(CSR_DEBOUNCE, '0);
      write_reg(CSR_LONG_HOLD, '0);
      write_reg(CSR_CHORD_HOLD, '0);
      queue_random(80);
      wait_drained();

      // all registers at their top value
      src_idling = 1'b1;
      sink_idling = 1'b1;
      write_reg(CSR_DEBOUNCE, '1);
      write_reg(CSR_LONG_HOLD, '1);
      write_reg(CSR_CHORD_HOLD, '1);
      queue_random(60);
      wait_drained();

      // spare index is dropped; receiver holds off while polls keep coming
      write_reg(CSR_SPARE, 16'h0005);
      write_reg(CSR_DEBOUNCE, 16'd7);
      write_reg(CSR_LONG_HOLD, 16'd40);
      write_reg(CSR_CHORD_HOLD, 16'd60);
      src_idling = 1'b0;
      queue_random(200);
      hold_off_asks++;
      wait_drained();

      // a few random settings
      repeat (3) begin
         src_idling = ($urandom_range(0, 3) != 0);
         sink_idling = ($urandom_range(0, 3) != 0);
         write_reg(CSR_DEBOUNCE, CFG_W'($urandom_range(0, 30)));
         write_reg(CSR_LONG_HOLD, CFG_W'($urandom_range(0, 400)));
         write_reg(CSR_CHORD_HOLD, CFG_W'($urandom_range(0, 600)));
         queue_random(130);
         wait_drained();
      end

      if (error_count == 0 && expected_events.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
